>>> hdl/srp_pkg.sv
// srp_pkg: shared widths, codes and the region entry layout of the shelf packer
// used by the packer top level, the uv divider and the port checker
// no dependencies

package srp_pkg;

  // field widths fixed by the interface
  localparam int DIM_W = 14;
  localparam int XY_W  = 13;
  localparam int ID_W  = 8;
  localparam int ST_W  = 3;

  // uv fixed point: fraction bits and result width (one integer bit)
  localparam int UV_FRAC_BITS = 16;
  localparam int UV_W         = UV_FRAC_BITS + 1;
  localparam logic [UV_W-1:0] UV_ONE = UV_W'(1) << UV_FRAC_BITS;

  // atlas size limits and padding
  localparam int MAX_DIM     = 8192;
  localparam int MIN_ATLAS   = 16;
  localparam int ATLAS_RESET = 1024;
  localparam int PAD_TOTAL   = 2;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = DIM_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;

  // operation codes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_BAD_ID    = 3'd4
  } status_t;

  // one region table entry: inner rectangle of a placed region
  typedef struct packed {
    logic [XY_W-1:0]  x;
    logic [XY_W-1:0]  y;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } region_t;

  localparam int REGION_W = $bits(region_t);

endpackage

>>> hdl/shelf_rect_packer_with_uv_lookup_unit.sv
// Shelf next-fit rectangle packer with region lookup in uv coordinates.
// An add pads the rectangle by one pixel on each side and places it at the
// cursor of the current shelf, opening a new shelf below when it does not fit;
// a lookup reads a placed region back. Inner rectangles live in a region ram
// of MAX_REGIONS entries with a registered read. Items are taken one at a
// time: an item passes through the ram read and placement decision, the
// divider load and four parallel bit-serial uv dividers (one quotient bit
// per cycle), and is then moved into the output register once that register
// is empty or not stalled; until then the item holds and no new beat is taken.
// The output register lets a new
// beat in while an earlier result still waits. A configuration write to the
// atlas width or height resets the atlas to empty.
// depends on srp_pkg, srp_ram, srp_uv_div

module shelf_rect_packer_with_uv_lookup_unit #(
  parameter int MAX_REGIONS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [srp_pkg::DIM_W-1:0]     in_tex_width,
  input  logic [srp_pkg::DIM_W-1:0]     in_tex_height,
  input  logic [srp_pkg::ID_W-1:0]      in_region_id,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srp_pkg::ST_W-1:0]      out_status,
  output logic [srp_pkg::ID_W-1:0]      out_assigned_id,
  output logic [srp_pkg::XY_W-1:0]      out_rect_x,
  output logic [srp_pkg::XY_W-1:0]      out_rect_y,
  output logic [srp_pkg::DIM_W-1:0]     out_rect_w,
  output logic [srp_pkg::DIM_W-1:0]     out_rect_h,
  output logic [srp_pkg::UV_W-1:0]      out_u_left,
  output logic [srp_pkg::UV_W-1:0]      out_v_top,
  output logic [srp_pkg::UV_W-1:0]      out_u_right,
  output logic [srp_pkg::UV_W-1:0]      out_v_bottom,
  // configuration port
  input  logic                          cfg_we,
  input  logic [srp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srp_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DW = srp_pkg::DIM_W;
  localparam int XW = srp_pkg::XY_W;
  localparam int IW = srp_pkg::ID_W;
  localparam int UW = srp_pkg::UV_W;
  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_LOAD = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // captured beat
  logic          op_r;
  logic [DW-1:0] tw_r, th_r;
  logic [IW-1:0] id_r;

  // configuration and shelf state
  logic [DW-1:0] aw_r, aw_nxt, ah_r, ah_nxt;
  logic [DW-1:0] cur_x_r, cur_x_nxt;
  logic [DW-1:0] top_y_r, top_y_nxt;
  logic [DW-1:0] shelf_h_r, shelf_h_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // result being computed
  srp_pkg::status_t res_status_r, res_status_nxt;
  logic [IW-1:0] res_id_r, res_id_nxt;
  logic [XW-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic [DW-1:0] res_w_r, res_w_nxt, res_h_r, res_h_nxt;
  logic          res_full_r, res_full_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [srp_pkg::ST_W-1:0] out_status_r;
  logic [IW-1:0] out_id_r;
  logic [XW-1:0] out_x_r, out_y_r;
  logic [DW-1:0] out_w_r, out_h_r;
  logic [UW-1:0] out_ul_r, out_vt_r, out_ur_r, out_vb_r;

  logic in_accept;
  logic out_load;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);

  // region ram
  logic [AW+IW-1:0]           rd_idx_ext;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  srp_pkg::region_t           wr_ent;
  logic [srp_pkg::REGION_W-1:0] rd_data;
  srp_pkg::region_t           rd_ent;

  assign rd_idx_ext = {AW'(0), in_region_id};
  assign rd_addr    = rd_idx_ext[AW-1:0];
  assign rd_ent     = srp_pkg::region_t'(rd_data);

  srp_ram #(
    .WIDTH (srp_pkg::REGION_W),
    .DEPTH (MAX_REGIONS)
  ) u_region_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // lookup check
  logic [CW+IW-1:0] id_cmp, count_cmp;
  logic             id_ok;

  assign id_cmp    = {CW'(0), id_r};
  assign count_cmp = {IW'(0), count_r};
  assign id_ok     = (id_cmp < count_cmp);

  // add placement decision
  logic [DW:0]   tw_pad, th_pad;
  logic          is_full, too_large, wrap, no_space, add_ok;
  logic [DW+1:0] x_end, y_end;
  logic [DW:0]   shelf_y;
  logic [DW-1:0] base_x, base_h, new_h;
  logic [DW:0]   base_x_end;
  logic [DW:0]   reg_x1, reg_y1;
  logic [CW+IW-1:0] count_ext;

  assign tw_pad    = {1'b0, tw_r} + (DW+1)'(srp_pkg::PAD_TOTAL);
  assign th_pad    = {1'b0, th_r} + (DW+1)'(srp_pkg::PAD_TOTAL);
  assign is_full   = (count_r == CW'(MAX_REGIONS));
  assign too_large = (tw_r == '0) || (th_r == '0) ||
                     (tw_pad > {1'b0, aw_r}) || (th_pad > {1'b0, ah_r});
  assign x_end     = {2'b0, cur_x_r} + {1'b0, tw_pad};
  assign wrap      = (x_end > {2'b0, aw_r});
  assign shelf_y   = wrap ? ({1'b0, top_y_r} + {1'b0, shelf_h_r}) : {1'b0, top_y_r};
  assign base_x    = wrap ? '0 : cur_x_r;
  assign base_h    = wrap ? '0 : shelf_h_r;
  assign y_end     = {1'b0, shelf_y} + {1'b0, th_pad};
  assign no_space  = (y_end > {2'b0, ah_r});
  assign add_ok    = !is_full && !too_large && !no_space;
  assign new_h     = (th_pad[DW-1:0] > base_h) ? th_pad[DW-1:0] : base_h;
  assign base_x_end = {1'b0, base_x} + tw_pad;
  assign reg_x1    = {1'b0, base_x} + (DW+1)'(1);
  assign reg_y1    = shelf_y + (DW+1)'(1);
  assign count_ext = {IW'(0), count_r};

  assign wr_en    = (state_r == S_EVAL) && (op_r == srp_pkg::OP_ADD) && add_ok;
  assign wr_addr  = count_r[AW-1:0];
  assign wr_ent.x = reg_x1[XW-1:0];
  assign wr_ent.y = reg_y1[XW-1:0];
  assign wr_ent.w = tw_r;
  assign wr_ent.h = th_r;

  // uv dividers, all four run in parallel
  logic [UW-1:0] q_ul, q_vt, q_ur, q_vb;
  logic          d_ul, d_vt, d_ur, d_vb;
  logic          div_start, div_done;
  logic [DW:0]   p_left, p_top, p_right, p_bottom;

  assign div_start = (state_r == S_LOAD);
  assign div_done  = d_ul && d_vt && d_ur && d_vb;
  assign p_left    = {2'b0, res_x_r};
  assign p_top     = {2'b0, res_y_r};
  assign p_right   = {2'b0, res_x_r} + {1'b0, res_w_r};
  assign p_bottom  = {2'b0, res_y_r} + {1'b0, res_h_r};

  srp_uv_div u_div_ul (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .p (p_left), .size (aw_r), .quot (q_ul), .done (d_ul)
  );

  srp_uv_div u_div_vt (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .p (p_top), .size (ah_r), .quot (q_vt), .done (d_vt)
  );

  srp_uv_div u_div_ur (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .p (p_right), .size (aw_r), .quot (q_ur), .done (d_ur)
  );

  srp_uv_div u_div_vb (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .p (p_bottom), .size (ah_r), .quot (q_vb), .done (d_vb)
  );

  assign out_load      = (state_r == S_DIV) && div_done && (!out_valid_r || !out_stall);
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_EVAL;
      end
      S_EVAL: state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result fields, decided in the evaluation cycle
  always_comb begin
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    res_w_nxt      = res_w_r;
    res_h_nxt      = res_h_r;
    res_full_nxt   = res_full_r;
    if (state_r == S_EVAL) begin
      res_x_nxt    = '0;
      res_y_nxt    = '0;
      res_w_nxt    = '0;
      res_h_nxt    = '0;
      res_full_nxt = 1'b1;
      res_id_nxt   = '0;
      if (op_r == srp_pkg::OP_LOOKUP) begin
        res_id_nxt = id_r;
        if (id_ok) begin
          res_status_nxt = srp_pkg::ST_OK;
          res_x_nxt      = rd_ent.x;
          res_y_nxt      = rd_ent.y;
          res_w_nxt      = rd_ent.w;
          res_h_nxt      = rd_ent.h;
          res_full_nxt   = 1'b0;
        end else begin
          res_status_nxt = srp_pkg::ST_BAD_ID;
        end
      end else if (is_full) begin
        res_status_nxt = srp_pkg::ST_FULL;
      end else if (too_large) begin
        res_status_nxt = srp_pkg::ST_TOO_LARGE;
      end else if (no_space) begin
        res_status_nxt = srp_pkg::ST_NO_SPACE;
      end else begin
        res_status_nxt = srp_pkg::ST_OK;
        res_id_nxt     = count_ext[IW-1:0];
        res_x_nxt      = reg_x1[XW-1:0];
        res_y_nxt      = reg_y1[XW-1:0];
        res_w_nxt      = tw_r;
        res_h_nxt      = th_r;
        res_full_nxt   = 1'b0;
      end
    end
  end

  // configuration writes and shelf updates
  logic [DW-1:0]    cfg_sat;

  always_comb begin
    if (cfg_data < DW'(srp_pkg::MIN_ATLAS)) begin
      cfg_sat = DW'(srp_pkg::MIN_ATLAS);
    end else if (cfg_data > DW'(srp_pkg::MAX_DIM)) begin
      cfg_sat = DW'(srp_pkg::MAX_DIM);
    end else begin
      cfg_sat = cfg_data;
    end
  end

  always_comb begin
    aw_nxt      = aw_r;
    ah_nxt      = ah_r;
    cur_x_nxt   = cur_x_r;
    top_y_nxt   = top_y_r;
    shelf_h_nxt = shelf_h_r;
    count_nxt   = count_r;
    if (wr_en) begin
      cur_x_nxt   = base_x_end[DW-1:0];
      top_y_nxt   = shelf_y[DW-1:0];
      shelf_h_nxt = new_h;
      count_nxt   = count_r + CW'(1);
    end
    if (cfg_we && (cfg_index == srp_pkg::CFG_ATLAS_WIDTH ||
                   cfg_index == srp_pkg::CFG_ATLAS_HEIGHT)) begin
      if (cfg_index == srp_pkg::CFG_ATLAS_WIDTH) begin
        aw_nxt = cfg_sat;
      end else begin
        ah_nxt = cfg_sat;
      end
      cur_x_nxt   = '0;
      top_y_nxt   = '0;
      shelf_h_nxt = '0;
      count_nxt   = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      aw_r        <= DW'(srp_pkg::ATLAS_RESET);
      ah_r        <= DW'(srp_pkg::ATLAS_RESET);
      cur_x_r     <= '0;
      top_y_r     <= '0;
      shelf_h_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      aw_r        <= aw_nxt;
      ah_r        <= ah_nxt;
      cur_x_r     <= cur_x_nxt;
      top_y_r     <= top_y_nxt;
      shelf_h_r   <= shelf_h_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // beat capture and result registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r <= in_operation;
      tw_r <= in_tex_width;
      th_r <= in_tex_height;
      id_r <= in_region_id;
    end
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    res_w_r      <= res_w_nxt;
    res_h_r      <= res_h_nxt;
    res_full_r   <= res_full_nxt;
  end

  // output register, failures show the full 0..1 rectangle
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_x_r      <= res_x_r;
      out_y_r      <= res_y_r;
      out_w_r      <= res_w_r;
      out_h_r      <= res_h_r;
      out_ul_r     <= res_full_r ? '0 : q_ul;
      out_vt_r     <= res_full_r ? '0 : q_vt;
      out_ur_r     <= res_full_r ? srp_pkg::UV_ONE : q_ur;
      out_vb_r     <= res_full_r ? srp_pkg::UV_ONE : q_vb;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_assigned_id = out_id_r;
  assign out_rect_x      = out_x_r;
  assign out_rect_y      = out_y_r;
  assign out_rect_w      = out_w_r;
  assign out_rect_h      = out_h_r;
  assign out_u_left      = out_ul_r;
  assign out_v_top       = out_vt_r;
  assign out_u_right     = out_ur_r;
  assign out_v_bottom    = out_vb_r;

endmodule

>>> hdl/srp_ram.sv
// srp_ram: generic single write port, single read port ram with registered read
// no dependencies

module srp_ram #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/srp_uv_div.sv
// srp_uv_div: bit-serial restoring divider for one uv coordinate
// computes (p * 2^UV_FRAC_BITS + size/2) / size, one quotient bit per cycle
// depends on srp_pkg

module srp_uv_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [srp_pkg::DIM_W:0]     p,
  input  logic [srp_pkg::DIM_W-1:0]   size,
  output logic [srp_pkg::UV_W-1:0]    quot,
  output logic                        done
);

  localparam int DW  = srp_pkg::DIM_W;
  localparam int QW  = srp_pkg::UV_W;
  localparam int NW  = DW + 1 + srp_pkg::UV_FRAC_BITS + 1;
  localparam int CNW = $clog2(QW + 1);

  logic [NW-1:0]  num_full;
  logic [DW-1:0]  rem_r, rem_nxt;
  logic [QW-1:0]  sh_r, sh_nxt;
  logic [QW-1:0]  q_r, q_nxt;
  logic [DW-1:0]  size_r, size_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [DW:0]    trial;
  logic [DW:0]    diff;
  logic           ge;

  // rounded numerator; its top bits stay below size, so they seed the remainder
  assign num_full = {1'b0, p, srp_pkg::UV_FRAC_BITS'(0)} + NW'(size >> 1);

  // one restoring step
  assign trial = {rem_r, sh_r[QW-1]};
  assign diff  = trial - {1'b0, size_r};
  assign ge    = (trial >= {1'b0, size_r});

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    size_nxt = size_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = num_full[QW+DW-1:QW];
      sh_nxt   = num_full[QW-1:0];
      size_nxt = size;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      sh_nxt  = {sh_r[QW-2:0], 1'b0};
      q_nxt   = {q_r[QW-2:0], ge};
      cnt_nxt = cnt_r + CNW'(1);
      if (cnt_r == CNW'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    sh_r   <= sh_nxt;
    q_r    <= q_nxt;
    size_r <= size_nxt;
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

>>> hdl/srp_checker.sv
// srp_checker: port-level assertions for the shelf packer, bound to its top level
// depends on srp_pkg and shelf_rect_packer_with_uv_lookup_unit

module srp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [srp_pkg::ST_W-1:0]  out_status,
  input logic [srp_pkg::DIM_W-1:0] out_rect_w,
  input logic [srp_pkg::DIM_W-1:0] out_rect_h,
  input logic [srp_pkg::UV_W-1:0]  out_u_left,
  input logic [srp_pkg::UV_W-1:0]  out_v_top,
  input logic [srp_pkg::UV_W-1:0]  out_u_right,
  input logic [srp_pkg::UV_W-1:0]  out_v_bottom
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
                                  $stable(out_u_right) && $stable(out_v_bottom)))
    else $error("stalled result beat changed");

  // one item at a time: an accepted beat closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a beat");

  // a placed or found region has ordered uv edges
  a_uv_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == srp_pkg::ST_OK) |->
      (out_u_left <= out_u_right && out_v_top <= out_v_bottom))
    else $error("uv edges out of order");

  // every failure shows an empty rectangle with full uv span
  a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != srp_pkg::ST_OK) |->
      (out_rect_w == '0 && out_rect_h == '0 && out_u_left == '0 &&
       out_v_top == '0 && out_u_right == srp_pkg::UV_ONE &&
       out_v_bottom == srp_pkg::UV_ONE))
    else $error("failure result not the full rectangle");

endmodule

bind shelf_rect_packer_with_uv_lookup_unit srp_checker u_srp_checker (.*);
